### rtl/sdet_pkg.sv
// ----------------------------------------------------------------------------
// sdet_pkg
// shared types and constants of the sorted descriptor event table
// ----------------------------------------------------------------------------
`default_nettype none

package sdet_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 16;
  localparam int MASK_BITS   = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [MASK_BITS-1:0] mask_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_LISTEN = 2'd1;
  localparam logic [1:0] ACT_CHECK  = 2'd2;
  localparam logic [1:0] ACT_REPORT = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_OR_WANTED,
    OP_INSERT,
    OP_STORE_RET
  } cell_op_t;

  typedef struct packed {
    key_t  key;
    mask_t wanted;
    mask_t returned;
  } entry_t;

  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
    key_t     key;
    mask_t    mask;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/sdet_cell.sv
// ----------------------------------------------------------------------------
// sdet_cell
// one table slot: compares its key and shifts from its left neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module sdet_cell
  import sdet_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       valid,
  input  wire logic       left_gp,
  input  wire entry_t     left_ent,
  output entry_t          ent,
  output logic            gp,
  output logic            eq
);

  entry_t ent_r;
  logic   gp_r;
  logic   eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      gp_r <= !valid || (ent_r.key >= ctrl.key);
      eq_r <= valid && (ent_r.key == ctrl.key);
    end
    case (ctrl.op)
      OP_INSERT: begin
        if (left_gp) begin
          ent_r <= left_ent;
        end else if (gp_r) begin
          ent_r.key      <= ctrl.key;
          ent_r.wanted   <= ctrl.mask;
          ent_r.returned <= '0;
        end
      end
      OP_OR_WANTED: begin
        if (eq_r) begin
          ent_r.wanted <= ent_r.wanted | ctrl.mask;
        end
      end
      OP_STORE_RET: begin
        if (eq_r) begin
          ent_r.returned <= ctrl.mask;
        end
      end
      default: begin
      end
    endcase
  end

  assign ent = ent_r;
  assign gp  = gp_r;
  assign eq  = eq_r;

endmodule

`default_nettype wire

### rtl/sorted_descriptor_event_table.sv
// ----------------------------------------------------------------------------
// sorted_descriptor_event_table
// sorted table of descriptor keys with wanted and returned event masks
// ----------------------------------------------------------------------------
// input beats carry an action in in_tuser and key and mask in in_tdata;
// every input beat yields exactly one output beat with hit bits, status
// and the entry count after the action.
// the table is a row of cells, one per slot, kept in ascending key order.
// on the accept edge every cell compares its key against the new key in
// parallel; in the apply state, once the output register is free, the cells
// apply the action (insert shifts every slot at or above the sorted place
// one cell to the right) and the result is loaded into the output register.
// in_tready is high only in the idle state, so each action passes through the
// compare then update pass of the cell row before the next beat is taken.
// the output register holds a result until taken; the update waits while
// an earlier result is still stalled, and no new beat is taken meanwhile.
// reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_descriptor_event_table
  import sdet_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // key[15:0], mask[31:16]
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // hit_bits[15:0], entry_count[22:16], zero pad
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_APPLY = 1'b1;

  logic        state_r, state_nxt;
  logic [1:0]  action_r;
  key_t        key_r;
  mask_t       mask_r;
  cnt_t        count_r, count_nxt;
  logic        out_tvalid_r;
  mask_t       hit_r, hit_nxt;
  logic [1:0]  status_r, status_nxt;

  logic        accept;
  logic        apply_go;
  logic        full;
  logic        found;
  mask_t       hit_raw;
  cell_ctrl_t  ctrl;
  cell_op_t    op;

  entry_t      ent [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gp;
  logic [TABLE_DEPTH-1:0] eq;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign apply_go  = (state_r == ST_APPLY) && (!out_tvalid_r || out_tready);
  assign full      = (count_r == cnt_t'(TABLE_DEPTH));

  always_comb begin
    found   = 1'b0;
    hit_raw = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      found   = found | eq[i];
      hit_raw = hit_raw | (eq[i] ? ent[i].returned : '0);
    end
  end

  always_comb begin
    op         = OP_NONE;
    count_nxt  = count_r;
    hit_nxt    = '0;
    status_nxt = STAT_OK;
    unique case (action_r)
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      ACT_LISTEN: begin
        if (found) begin
          op = OP_OR_WANTED;
        end else if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          op        = OP_INSERT;
          count_nxt = count_r + cnt_t'(1);
        end
      end
      ACT_CHECK: begin
        if (found) begin
          hit_nxt = hit_raw & mask_r;
        end else begin
          status_nxt = STAT_MISS;
        end
      end
      ACT_REPORT: begin
        if (found) begin
          op = OP_STORE_RET;
        end else begin
          status_nxt = STAT_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.op     = apply_go ? op : OP_NONE;
    ctrl.key    = accept ? in_tdata[15:0] : key_r;
    ctrl.mask   = mask_r;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic   lgp;
      entry_t lent;
      if (g == 0) begin : g_first
        assign lgp  = 1'b0;
        assign lent = '0;
      end else begin : g_rest
        assign lgp  = gp[g-1];
        assign lent = ent[g-1];
      end
      sdet_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .valid    (cnt_t'(g) < count_r),
        .left_gp  (lgp),
        .left_ent (lent),
        .ent      (ent[g]),
        .gp       (gp[g]),
        .eq       (eq[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_tuser;
      key_r    <= in_tdata[15:0];
      mask_r   <= in_tdata[31:16];
    end
    if (apply_go) begin
      hit_r    <= hit_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, count_r, hit_r};
  assign out_tuser  = status_r;

endmodule

`default_nettype wire

### bench/sorted_descriptor_event_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_descriptor_event_table_test
// self-checking bench for the sorted descriptor event table
// ----------------------------------------------------------------------------
// drives clear, listen, check and report actions over the input stream and
// keeps its own sorted copy of the table to predict every output beat.
// a directed opening covers the key and mask extremes, insert in the middle,
// or into a present key, checks and reports on absent keys and clear.
// each phase then fills the table to its depth, probes the full case and
// runs random actions biased toward keys already present. the phases vary
// sender gaps and receiver stalls; one long receiver hold backs the block
// up while beats keep being offered.
// ----------------------------------------------------------------------------

module sorted_descriptor_event_table_test;
  import sdet_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;

  typedef struct packed {
    mask_t      hit;
    logic [1:0] status;
    cnt_t       count;
  } table_result_t;

  class event_table_scoreboard;
    key_t          keys[TABLE_DEPTH];
    mask_t         wanted[TABLE_DEPTH];
    mask_t         returned[TABLE_DEPTH];
    int unsigned   used;
    table_result_t pending[$];
    int            errors;

    function void note_action(logic [1:0] act, key_t k, mask_t m);
      int unsigned   pos;
      bit            found;
      table_result_t r;
      pos = used;
      for (int i = 0; i < used; i++)
        if (pos == used && keys[i] >= k) pos = i;
      found = (pos < used) && (keys[pos] == k);
      r.hit = '0;
      r.status = STAT_OK;
      case (act)
        ACT_CLEAR: begin
          used = 0;
        end
        ACT_LISTEN: begin
          if (found) begin
            wanted[pos] = wanted[pos] | m;
          end else if (used >= TABLE_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (int j = used; j > pos; j--) begin
              keys[j] = keys[j-1];
              wanted[j] = wanted[j-1];
              returned[j] = returned[j-1];
            end
            keys[pos] = k;
            wanted[pos] = m;
            returned[pos] = '0;
            used++;
          end
        end
        ACT_CHECK: begin
          if (found) r.hit = returned[pos] & m;
          else r.status = STAT_MISS;
        end
        default: begin
          if (found) returned[pos] = m;
          else r.status = STAT_MISS;
        end
      endcase
      r.count = cnt_t'(used);
      pending.push_back(r);
    endfunction

    function void check_result(mask_t hit, logic [1:0] status, cnt_t count);
      table_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with no action outstanding");
        errors++;
      end else begin
        e = pending.pop_front();
        if (hit !== e.hit) begin
          $error("hit_bits expected %h got %h", e.hit, hit);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d got %0d", e.status, status);
          errors++;
        end
        if (count !== e.count) begin
          $error("entry_count expected %0d got %0d", e.count, count);
          errors++;
        end
      end
    endfunction

    // a present key, now and then its upper neighbor
    function key_t pick_key();
      key_t k;
      k = keys[$urandom_range(used - 1)];
      if ($urandom_range(7) == 0) k = k + 1'b1;
      return k;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // key[15:0], mask[31:16]
  logic [1:0]  in_tuser = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // hit_bits[15:0], entry_count[22:16], zero pad
  logic [1:0]  out_tuser;       // status[1:0]

  event_table_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int idle_cycles = 0;

  sorted_descriptor_event_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // receiver: random stalls plus one long hold
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[15:0], out_tuser, out_tdata[16 +: CNT_W]);
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [1:0] act, input key_t k, input mask_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {m, k};
    in_tuser <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_action(act, k, m);
  endtask

  function automatic key_t random_key();
    if ($urandom_range(1) == 0) return key_t'($urandom_range(127));
    return key_t'($urandom_range(65535));
  endfunction

  function automatic mask_t random_mask();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return mask_t'($urandom_range(65535));
    endcase
  endfunction

  task automatic fill_table();
    while (sb.used < TABLE_DEPTH)
      send_beat(ACT_LISTEN, random_key(), random_mask());
    // full: absent key dropped, present key still ORed
    send_beat(ACT_LISTEN, key_t'($urandom_range(65535)), random_mask());
    send_beat(ACT_LISTEN, sb.pick_key(), random_mask());
    send_beat(ACT_CHECK, sb.pick_key(), random_mask());
  endtask

  task automatic random_action(input int clear_pct);
    int         r;
    logic [1:0] act;
    key_t       k;
    r = $urandom_range(99);
    if (r < clear_pct) act = ACT_CLEAR;
    else if (r < 45) act = ACT_LISTEN;
    else if (r < 72) act = ACT_CHECK;
    else act = ACT_REPORT;
    if (sb.used != 0 && $urandom_range(2) != 0) k = sb.pick_key();
    else k = random_key();
    send_beat(act, k, random_mask());
  endtask

  task automatic run_directed();
    send_beat(ACT_CHECK, 16'h0000, 16'hFFFF);
    send_beat(ACT_REPORT, 16'hFFFF, 16'hFFFF);
    send_beat(ACT_LISTEN, 16'h0000, 16'hFFFF);
    send_beat(ACT_LISTEN, 16'hFFFF, 16'h0000);
    send_beat(ACT_LISTEN, 16'h8000, 16'hA5A5);
    send_beat(ACT_LISTEN, 16'h0001, 16'h5A5A);
    send_beat(ACT_LISTEN, 16'h8000, 16'h0F0F);
    send_beat(ACT_REPORT, 16'hFFFF, 16'hFFFF);
    send_beat(ACT_CHECK, 16'hFFFF, 16'hFFFF);
    send_beat(ACT_CHECK, 16'hFFFF, 16'h0000);
    send_beat(ACT_REPORT, 16'h0000, 16'h1234);
    send_beat(ACT_LISTEN, 16'h0000, 16'h0000);
    send_beat(ACT_CHECK, 16'h0000, 16'hFFFF);
    send_beat(ACT_CHECK, 16'h7FFF, 16'hFFFF);
    send_beat(ACT_REPORT, 16'h7FFF, 16'hFFFF);
    send_beat(ACT_CHECK, 16'h8000, 16'hFFFF);
    send_beat(ACT_CHECK, 16'h0001, 16'h5A5A);
    send_beat(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
    send_beat(ACT_CHECK, 16'h0000, 16'hFFFF);
    send_beat(ACT_CLEAR, 16'h0000, 16'h0000);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 63;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct <= 23;
        end
      endcase
      if (ph == 0) begin
        run_directed();
        hold_req <= 1'b1;
      end
      send_beat(ACT_CLEAR, random_key(), random_mask());
      fill_table();
      repeat (60) random_action(3);
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
